/* src/stt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_pkg
// Shared constants, status codes and controller/datapath handshake structs
// for the sleep timer table.
// ----------------------------------------------------------------------------
package stt_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [15:0] TICK_PERIOD_RESET = 16'd55;

   // transaction kinds
   localparam logic [1:0] KIND_SLEEP  = 2'd0;
   localparam logic [1:0] KIND_CANCEL = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // result status codes
   localparam logic [2:0] ST_QUEUED   = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_SHORT    = 3'd2;
   localparam logic [2:0] ST_REMOVED  = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;
   localparam logic [2:0] ST_WOKEN    = 3'd5;
   localparam logic [2:0] ST_NONE     = 3'd6;

   // controller -> datapath
   typedef struct packed {
      logic capture;      // latch request, reset walk pointers
      logic sleep_done;   // insert or refuse, post sleep result
      logic cancel_step;  // test current entry, remove on match
      logic cancel_miss;  // post not-found
      logic tick_step;    // decrement current entry, wake on zero
      logic tick_end;     // post final tick result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic walk_done;
      logic match;
      logic out_free;
      logic tick_ok;
   } stat_type;

endpackage
`default_nettype wire

/* src/stt_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_req_if
// Request channel: sleep, cancel and tick transactions.
// ----------------------------------------------------------------------------
interface stt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [31:0] duration_ms;
   logic [7:0]  process_id;
   logic [5:0]  thread_id;

   modport source (output valid, kind, duration_ms, process_id, thread_id,
                   input ready);
   modport sink   (input valid, kind, duration_ms, process_id, thread_id,
                   output ready);
endinterface
`default_nettype wire

/* src/stt_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_rsp_if
// Response channel: one or more results per request transaction.
// ----------------------------------------------------------------------------
interface stt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] woken_process;
   logic [5:0] woken_thread;
   logic       last;

   modport source (output valid, status, woken_process, woken_thread, last,
                   input ready);
   modport sink   (input valid, status, woken_process, woken_thread, last,
                   output ready);
endinterface
`default_nettype wire

/* src/stt_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_divider
// Restoring divider, 32-bit dividend by 16-bit divisor, one quotient bit
// per cycle. done stays high from completion until the next start.
// ----------------------------------------------------------------------------
module stt_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [16:0] rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      rem_sh  = {rem_ff, quo_ff[31]};
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = 5'd0;
         quo_in  = dividend;
         rem_in  = 16'd0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = 16'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh[15:0];
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= 5'd0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

/* src/stt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_datapath
// Slot table, sleeper list, tick period register, divider, one-deep wake
// holding register and the response output register.
// ----------------------------------------------------------------------------
module stt_datapath (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire stt_pkg::cmd_type   cmd,
   output stt_pkg::stat_type       stat,
   input  wire logic [1:0]         req_kind,
   input  wire logic [31:0]        req_duration_ms,
   input  wire logic [7:0]         req_process_id,
   input  wire logic [5:0]         req_thread_id,
   input  wire logic               csr_wr_en,
   input  wire logic [15:0]        csr_wr_data,
   input  wire logic               rsp_ready,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_status,
   output logic [7:0]              rsp_woken_process,
   output logic [5:0]              rsp_woken_thread,
   output logic                    rsp_last
);

   localparam int IW = stt_pkg::IDX_W;
   localparam int CW = stt_pkg::CNT_W;
   localparam int NS = stt_pkg::SLOTS;

   // slot table
   logic [NS-1:0] used_ff;
   logic [7:0]    proc_ff  [NS];
   logic [5:0]    thr_ff   [NS];
   logic [31:0]   ticks_ff [NS];
   logic [IW-1:0] next_ff  [NS];

   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   period_ff;

   // walk state and captured request
   logic [IW-1:0] cur_ff, cur_in;
   logic [IW-1:0] prev_ff, prev_in;
   logic [CW-1:0] steps_ff, steps_in;
   logic [CW-1:0] walk_n_ff;
   logic [7:0]    pid_ff;
   logic [5:0]    tid_ff;

   // wake holding register
   logic          hold_vld_ff, hold_vld_in;
   logic [7:0]    hold_p_ff, hold_p_in;
   logic [5:0]    hold_t_ff, hold_t_in;

   // output register
   logic          out_vld_ff, out_vld_in;
   logic [2:0]    out_st_ff;
   logic [7:0]    out_p_ff;
   logic [5:0]    out_t_ff;
   logic          out_last_ff;

   logic          div_start, div_done;
   logic [31:0]   div_q;
   logic [15:0]   divisor;

   logic [IW-1:0] free_idx;
   logic          free_found;
   logic [31:0]   dec;
   logic          wake, match, out_free, do_unlink, do_insert;
   logic          emit, emit_last;
   logic [2:0]    emit_st;
   logic [7:0]    emit_p;
   logic [5:0]    emit_t;

   assign divisor   = (period_ff == 16'd0) ? 16'd1 : period_ff;
   assign div_start = cmd.capture && (req_kind == stt_pkg::KIND_SLEEP);

   stt_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_duration_ms),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   // lowest free slot
   always_comb begin
      free_idx   = '0;
      free_found = 1'b0;
      for (int i = NS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_idx   = IW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign dec      = ticks_ff[cur_ff] - 32'd1;
   assign wake     = (dec == 32'd0);
   assign match    = (proc_ff[cur_ff] == pid_ff) && (thr_ff[cur_ff] == tid_ff);
   assign out_free = !out_vld_ff || rsp_ready;

   assign do_insert = cmd.sleep_done && (div_q != 32'd0) && free_found &&
                      (count_ff < CW'(NS));
   assign do_unlink = (cmd.cancel_step && match) || (cmd.tick_step && wake);

   // result selection
   always_comb begin
      emit      = 1'b0;
      emit_st   = stt_pkg::ST_NONE;
      emit_p    = 8'd0;
      emit_t    = 6'd0;
      emit_last = 1'b1;
      if (cmd.sleep_done) begin
         emit = 1'b1;
         if (div_q == 32'd0)
            emit_st = stt_pkg::ST_SHORT;
         else if (do_insert)
            emit_st = stt_pkg::ST_QUEUED;
         else
            emit_st = stt_pkg::ST_FULL;
      end else if (cmd.cancel_step && match) begin
         emit    = 1'b1;
         emit_st = stt_pkg::ST_REMOVED;
         emit_p  = pid_ff;
         emit_t  = tid_ff;
      end else if (cmd.cancel_miss) begin
         emit    = 1'b1;
         emit_st = stt_pkg::ST_NOTFOUND;
      end else if (cmd.tick_step && wake && hold_vld_ff) begin
         emit      = 1'b1;
         emit_st   = stt_pkg::ST_WOKEN;
         emit_p    = hold_p_ff;
         emit_t    = hold_t_ff;
         emit_last = 1'b0;
      end else if (cmd.tick_end) begin
         emit = 1'b1;
         if (hold_vld_ff) begin
            emit_st = stt_pkg::ST_WOKEN;
            emit_p  = hold_p_ff;
            emit_t  = hold_t_ff;
         end
      end
   end

   // list pointers, walk state, hold register
   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      steps_in    = steps_ff;
      hold_vld_in = hold_vld_ff;
      hold_p_in   = hold_p_ff;
      hold_t_in   = hold_t_ff;
      out_vld_in  = out_vld_ff;

      if (cmd.capture) begin
         cur_in      = head_ff;
         prev_in     = head_ff;
         steps_in    = '0;
         hold_vld_in = 1'b0;
      end
      if (do_insert) begin
         head_in  = free_idx;
         count_in = count_ff + CW'(1);
      end
      if (do_unlink) begin
         if (cur_ff == head_ff)
            head_in = next_ff[cur_ff];
         count_in = count_ff - CW'(1);
      end
      if (cmd.cancel_step || cmd.tick_step) begin
         if (!do_unlink)
            prev_in = cur_ff;
         cur_in   = next_ff[cur_ff];
         steps_in = steps_ff + CW'(1);
      end
      if (cmd.tick_step && wake) begin
         hold_vld_in = 1'b1;
         hold_p_in   = proc_ff[cur_ff];
         hold_t_in   = thr_ff[cur_ff];
      end

      if (emit)
         out_vld_in = 1'b1;
      else if (rsp_ready)
         out_vld_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff     <= '0;
         head_ff     <= '0;
         count_ff    <= '0;
         period_ff   <= stt_pkg::TICK_PERIOD_RESET;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
         steps_ff    <= '0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
         steps_ff    <= steps_in;
         if (csr_wr_en)
            period_ff <= csr_wr_data;
         if (do_insert)
            used_ff[free_idx] <= 1'b1;
         if (do_unlink)
            used_ff[cur_ff] <= 1'b0;
      end
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      hold_p_ff <= hold_p_in;
      hold_t_ff <= hold_t_in;
      if (cmd.capture) begin
         walk_n_ff <= count_ff;
         pid_ff    <= req_process_id;
         tid_ff    <= req_thread_id;
      end
      if (emit) begin
         out_st_ff   <= emit_st;
         out_p_ff    <= emit_p;
         out_t_ff    <= emit_t;
         out_last_ff <= emit_last;
      end
   end

   // table entries
   always_ff @(posedge clock) begin
      if (do_insert) begin
         proc_ff[free_idx]  <= pid_ff;
         thr_ff[free_idx]   <= tid_ff;
         ticks_ff[free_idx] <= div_q;
         next_ff[free_idx]  <= head_ff;
      end
      if (cmd.tick_step)
         ticks_ff[cur_ff] <= dec;
      if (do_unlink && (cur_ff != head_ff))
         next_ff[prev_ff] <= next_ff[cur_ff];
   end

   assign stat.div_done  = div_done;
   assign stat.walk_done = (steps_ff == walk_n_ff);
   assign stat.match     = match;
   assign stat.out_free  = out_free;
   assign stat.tick_ok   = out_free || !(wake && hold_vld_ff);

   assign rsp_valid         = out_vld_ff;
   assign rsp_status        = out_st_ff;
   assign rsp_woken_process = out_p_ff;
   assign rsp_woken_thread  = out_t_ff;
   assign rsp_last          = out_last_ff;

   // occupancy count tracks the used bits
   a_count_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == 32'(count_ff))
      else $error("sleeper count out of step with used slots");

   // a result is only posted into a free output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free)
      else $error("result posted while output register busy");

   // the closing tick result always carries last
   a_tick_last: assert property (@(posedge clock) disable iff (reset)
      cmd.tick_end |=> out_vld_ff && out_last_ff)
      else $error("tick end did not post a last result");

   // a removal always targets a slot in use
   a_unlink_used: assert property (@(posedge clock) disable iff (reset)
      do_unlink |-> used_ff[cur_ff])
      else $error("removal of a free slot");

endmodule
`default_nettype wire

/* src/stt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stt_ctrl
// Sequencer: accepts one request transaction at a time and steps the
// datapath through divide, list walk and result posting.
// ----------------------------------------------------------------------------
module stt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [1:0]        req_kind,
   output logic                   req_ready,
   input  wire stt_pkg::stat_type stat,
   output stt_pkg::cmd_type       cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DIV      = 3'd1;
   localparam logic [2:0] S_SLEEP    = 3'd2;
   localparam logic [2:0] S_CANCEL   = 3'd3;
   localparam logic [2:0] S_TICK     = 3'd4;
   localparam logic [2:0] S_TICK_END = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               case (req_kind)
                  stt_pkg::KIND_SLEEP:  state_in = S_DIV;
                  stt_pkg::KIND_CANCEL: state_in = S_CANCEL;
                  stt_pkg::KIND_TICK:   state_in = S_TICK;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_DIV: begin
            if (stat.div_done)
               state_in = S_SLEEP;
         end
         S_SLEEP: begin
            if (stat.out_free) begin
               cmd.sleep_done = 1'b1;
               state_in       = S_IDLE;
            end
         end
         S_CANCEL: begin
            if (stat.walk_done) begin
               if (stat.out_free) begin
                  cmd.cancel_miss = 1'b1;
                  state_in        = S_IDLE;
               end
            end else if (!stat.match) begin
               cmd.cancel_step = 1'b1;
            end else if (stat.out_free) begin
               cmd.cancel_step = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_TICK: begin
            if (stat.walk_done)
               state_in = S_TICK_END;
            else if (stat.tick_ok)
               cmd.tick_step = 1'b1;
         end
         S_TICK_END: begin
            if (stat.out_free) begin
               cmd.tick_end = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= S_IDLE;
      else
         state_ff <= state_in;
   end

   // a walk step is never issued once the walk is complete
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (cmd.cancel_step || cmd.tick_step) |-> !stat.walk_done)
      else $error("walk stepped past the sleeper list");

   // a sleep transaction reaches the result state only with a quotient
   a_div_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SLEEP) |-> stat.div_done)
      else $error("sleep result without finished division");

   // a new request is captured only from idle
   a_capture_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> $past(state_in) == S_IDLE || state_ff == S_IDLE)
      else $error("request captured outside idle");

endmodule
`default_nettype wire

/* src/sleep_timer_table.sv */
`default_nettype none
// Sleep: the result is posted once the divider has produced its quotient;
//   cancel and tick walk one list entry per cycle while the response side
//   does not stall, and cancel posts its result on a match or after the walk.
// Throughput: one request transaction at a time; a new request is accepted
//   only once the sequencer is back in idle.
// Reset: synchronous, active high; clears the list, all slots free,
//   tick period back to 55 ms. Slot contents are not cleared.
// ----------------------------------------------------------------------------
// sleep_timer_table
// Table of sleeping threads with tick countdowns, kept as a most-recent-first
// linked list. Sleep converts ms to ticks, cancel removes the first match,
// tick counts every entry down and reports the ones that reach zero.
// ----------------------------------------------------------------------------
module sleep_timer_table (
   input  wire logic        clock,
   input  wire logic        reset,
   stt_req_if.sink          req_if,
   stt_rsp_if.source        rsp_if,
   input  wire logic        csr_wr_en,
   input  wire logic [15:0] csr_wr_data
);

   // command / status between sequencer and datapath
   stt_pkg::cmd_type  cmd;
   stt_pkg::stat_type stat;

   // sequencer: owns req ready, one transaction in flight
   stt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_kind  (req_if.kind),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: table, divider, output register driving the response side
   stt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_kind          (req_if.kind),
      .req_duration_ms   (req_if.duration_ms),
      .req_process_id    (req_if.process_id),
      .req_thread_id     (req_if.thread_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_status        (rsp_if.status),
      .rsp_woken_process (rsp_if.woken_process),
      .rsp_woken_thread  (rsp_if.woken_thread),
      .rsp_last          (rsp_if.last)
   );

endmodule
`default_nettype wire
